[hw/rtl/tsfp_pkg.sv]
// Shared types and constants for the time-of-flight sensor frame parser.
// No dependencies; imported by every module of the block.
package tsfp_pkg;

    // Receive capacity of one frame in bytes.
    localparam int RX_CAPACITY = 64;
    localparam int CNT_W       = $clog2(RX_CAPACITY + 1);

    // Frame layout.
    localparam int FRAME_LEN   = 27;
    localparam int BODY_LEN    = 26;
    localparam int BODY_IDX_W  = $clog2(BODY_LEN);
    localparam logic [7:0] HDR0 = 8'h5A;
    localparam logic [7:0] HDR1 = 8'h8E;
    localparam logic [7:0] HDR2 = 8'h17;

    // Reported length is a 7-bit field.
    localparam int LEN_W       = 7;
    localparam int LEN_MAX     = 127;

    // Output beat width: 191 payload bits padded to whole bytes.
    localparam int OUT_W       = 192;

    // Queue between the front and back parts.
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    // Item kinds carried in the input tuser bit.
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_IDLE  = 1'b1;

    typedef struct packed {
        logic       is_idle;
        logic [7:0] data;
    } q_entry_t;

endpackage

[hw/rtl/tsfp_front.sv]
// Front part of the frame parser: accepts input beats, classifies them as
// data bytes or line-idle events and queues them for the back part.
// Depends on tsfp_pkg.
module tsfp_front
    import tsfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] command
    output logic       q_valid,
    input  logic       q_ready,
    output q_entry_t   q_entry
);

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W:0]     wr_ptr_reg;
    logic [QPTR_W:0]     wr_ptr_next;
    logic [QPTR_W:0]     rd_ptr_reg;
    logic [QPTR_W:0]     rd_ptr_next;
    logic                full;
    logic                empty;
    logic                push;
    logic                pop;
    q_entry_t            in_entry;

    // Pointers carry one extra wrap bit to tell full from empty.
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QPTR_W] != rd_ptr_reg[QPTR_W])
                && (wr_ptr_reg[QPTR_W-1:0] == rd_ptr_reg[QPTR_W-1:0]);

    assign s_tready = !full;
    assign push     = s_tvalid && !full;
    assign q_valid  = !empty;
    assign pop      = q_ready && !empty;
    assign q_entry  = mem_reg[rd_ptr_reg[QPTR_W-1:0]];

    always_comb
    begin
        in_entry.is_idle = (s_tuser == CMD_IDLE);
        in_entry.data    = s_tdata;
        wr_ptr_next      = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next      = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg[QPTR_W-1:0]] <= in_entry;
        end
    end

endmodule

[hw/rtl/tsfp_back.sv]
// Back part of the frame parser: counts, sums and stores frame bytes, and on
// a line-idle event checks the frame and loads the decoded result register.
// Depends on tsfp_pkg.
module tsfp_back
    import tsfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  q_entry_t         q_entry,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser
);

    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [CNT_W-1:0]  count_reg;
    logic [7:0]        sum_reg;
    logic [7:0]        last_reg;
    logic              ovf_reg;
    logic [7:0]        body_reg [BODY_LEN];
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              out_ok_reg;

    logic              pop;
    logic              pop_data;
    logic              pop_idle;
    logic              in_body;
    logic              at_cap;
    logic              ok;
    logic [CMP_W-1:0]  cnt_ext;
    logic [LEN_W-1:0]  len;
    logic [OUT_W-1:0]  result;

    // Data bytes never stall; an idle event waits for room in the output.
    assign q_ready  = !q_entry.is_idle || !out_valid_reg || m_tready;
    assign pop      = q_valid && q_ready;
    assign pop_data = pop && !q_entry.is_idle;
    assign pop_idle = pop && q_entry.is_idle;
    assign at_cap   = (count_reg == CNT_W'(RX_CAPACITY));
    assign in_body  = (count_reg < CNT_W'(BODY_LEN));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    always_comb
    begin
        ok = !ovf_reg
          && (count_reg == CNT_W'(FRAME_LEN))
          && (body_reg[0] == HDR0)
          && (body_reg[1] == HDR1)
          && (body_reg[2] == HDR2)
          && (sum_reg == last_reg);

        cnt_ext = CMP_W'(count_reg);
        len     = (cnt_ext > CMP_W'(LEN_MAX)) ? LEN_W'(LEN_MAX) : cnt_ext[LEN_W-1:0];

        result = '0;
        result[6:0] = len;
        if (ok)
        begin
            result[22:7]    = {body_reg[4], body_reg[3]};
            result[38:23]   = {body_reg[6], body_reg[5]};
            result[62:39]   = {body_reg[9], body_reg[8], body_reg[7]};
            result[78:63]   = {body_reg[11], body_reg[10]};
            result[94:79]   = {body_reg[13], body_reg[12]};
            result[118:95]  = {body_reg[16], body_reg[15], body_reg[14]};
            result[134:119] = {body_reg[18], body_reg[17]};
            result[166:135] = {body_reg[22], body_reg[21], body_reg[20], body_reg[19]};
            result[182:167] = {body_reg[24], body_reg[23]};
            result[190:183] = body_reg[25];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            sum_reg       <= '0;
            last_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_data)
            begin
                if (at_cap)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    if (in_body)
                    begin
                        sum_reg <= sum_reg + q_entry.data;
                    end
                    last_reg  <= q_entry.data;
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (pop_idle)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                last_reg  <= '0;
                ovf_reg   <= 1'b0;
            end

            if (pop_idle)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Frame store and result payload need no reset.
    always_ff @(posedge clk)
    begin
        if (pop_data && !at_cap && in_body)
        begin
            body_reg[count_reg[BODY_IDX_W-1:0]] <= q_entry.data;
        end
        if (pop_idle)
        begin
            out_data_reg <= result;
            out_ok_reg   <= ok;
        end
    end

endmodule

[hw/rtl/tof_sensor_frame_parser.sv]
// Top level of the time-of-flight sensor frame parser.
// Depends on tsfp_pkg, tsfp_front and tsfp_back.
//
// The parser takes one beat per clock while its input queue has room: a data
// byte (tuser 0) or a line-idle event (tuser 1). Each idle beat yields one
// result beat, passing through the four-entry input queue and then the result
// register. Data beats are absorbed at one per cycle; an idle beat waits only
// while an earlier result is still held by the downstream side, and the queue
// keeps accepting until it fills. A frame is reported good when it holds
// exactly 27 bytes, starts with 5A 8E 17 and its last byte equals the low
// byte of the sum of the first 26; decoded fields read zero otherwise.
module tof_sensor_frame_parser
    import tsfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    input  logic             s_tuser,   // [0] command
    output logic             m_tvalid,
    input  logic             m_tready,
    // [6:0] frame_length, [22:7] flight_time, [38:23] signal_peak,
    // [62:39] noise_floor, [78:63] multishot, [94:79] damped_peak,
    // [118:95] damped_noise, [134:119] ref_tof, [166:135] temperature,
    // [182:167] cal_distance, [190:183] confidence, [191] zero
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser    // [0] frame_ok
);

    logic     q_valid;
    logic     q_ready;
    q_entry_t q_entry;

    tsfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    tsfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
